// ----- rtl/vfsr_pkg.sv -----
// Shared constants for the video frame shard reassembly block.
// Used by the top level, the shard-count divider and the port checker.
package vfsr_pkg;

	// Default geometry.
	localparam int SHARD_WORDS_DEF = 128;
	localparam int MAX_SHARDS_DEF  = 64;

	// Field widths.
	localparam int FUNC_W    = 2;
	localparam int FRAME_W   = 64;
	localparam int SIZE_W    = 16;
	localparam int SHARD_W   = 6;
	localparam int OFFSET_W  = 7;
	localparam int WORD_W    = 64;
	localparam int COUNT_W   = 4;
	localparam int STORE_AW  = 13;
	localparam int STATUS_W  = 2;
	localparam int CNT_W     = 7;

	// Frame buffer and bookkeeping.
	localparam int STORE_DEPTH    = 1 << STORE_AW;
	localparam int MARK_W         = 1 << SHARD_W;
	localparam int BYTES_PER_WORD = WORD_W / 8;
	localparam int ADDR_CALC_W    = 17;
	localparam int SHARD_CNT_MAX  = 127;

	// Function codes.
	localparam logic [FUNC_W-1:0] FUNC_PACKET = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RECOVERED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage

// ----- rtl/vfsr_div.sv -----
// Division of the frame size by a constant shard byte size, done as a multiplication
// by the rounded-up reciprocal; the quotient is registered and ready in the cycle after start.
// Depends on vfsr_pkg for the size width and the default shard size.
module vfsr_div #(
	parameter int DIVISOR = vfsr_pkg::SHARD_WORDS_DEF * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vfsr_pkg::SIZE_W-1:0] dividend,
	output logic                        done,
	output logic [vfsr_pkg::SIZE_W-1:0] quotient
);
	localparam int NW = vfsr_pkg::SIZE_W;
	localparam int LW = $clog2(DIVISOR);
	localparam int SH = NW + LW;
	localparam int RW = NW + 2;
	localparam int PW = NW + RW;
	localparam logic [RW-1:0] RECIP =
		RW'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

	logic [PW-1:0] prod_q;
	logic          busy_q;

	// The rounding error of the reciprocal times any dividend below 2**NW stays under
	// one part in the divisor, so the shifted product is the exact quotient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(dividend) * PW'(RECIP);
		end
	end

	assign done     = !busy_q;
	assign quotient = NW'(prod_q >> SH);

endmodule

// ----- rtl/video_frame_shard_reassembly.sv -----
// Video frame shard reassembly: each command is registered when accepted and, but for
// FUNC_NONE, executed in the execute state, which waits while the output register is
// full; no command is accepted until the last one has executed. The frame buffer is a
// single-port-write memory with a registered read, and a payload word is merged into
// the word read back in the accept cycle. The first header of a new frame index starts
// a clearing sweep over all 8192 buffer words during which no item is accepted; the
// same sweep runs once after reset. The shard count of the new frame comes from a
// multiplication by the reciprocal of the shard byte size, latched as the sweep starts.
// Depends on vfsr_pkg and vfsr_div.
module video_frame_shard_reassembly #(
	parameter int SHARD_WORDS = vfsr_pkg::SHARD_WORDS_DEF,
	parameter int MAX_SHARDS  = vfsr_pkg::MAX_SHARDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vfsr_pkg::FUNC_W-1:0]   func,
	input  logic [vfsr_pkg::FRAME_W-1:0]  frame_index,
	input  logic [vfsr_pkg::SIZE_W-1:0]   frame_size_bytes,
	input  logic [vfsr_pkg::SHARD_W-1:0]  shard_index,
	input  logic                          first_word,
	input  logic [vfsr_pkg::OFFSET_W-1:0] word_offset,
	input  logic [vfsr_pkg::WORD_W-1:0]   payload_word,
	input  logic [vfsr_pkg::COUNT_W-1:0]  byte_count,
	input  logic [vfsr_pkg::STORE_AW-1:0] read_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vfsr_pkg::STATUS_W-1:0] status,
	output logic                          recovered_now,
	output logic [vfsr_pkg::WORD_W-1:0]   read_data,
	output logic [vfsr_pkg::SIZE_W-1:0]   frame_size_out,
	output logic [vfsr_pkg::CNT_W-1:0]    shards_received
);
	localparam int AW  = vfsr_pkg::STORE_AW;
	localparam int WW  = vfsr_pkg::WORD_W;
	localparam int NB  = vfsr_pkg::BYTES_PER_WORD;
	localparam int ACW = vfsr_pkg::ADDR_CALC_W;
	localparam int CNW = vfsr_pkg::CNT_W;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	// Control.
	logic [1:0]    state_q;
	logic [AW-1:0] sweep_q;
	logic          ret_exec_q;
	logic          fresh_q;

	// Registered item.
	logic [vfsr_pkg::FUNC_W-1:0]   func_q;
	logic [vfsr_pkg::FRAME_W-1:0]  frame_q;
	logic [vfsr_pkg::SIZE_W-1:0]   size_in_q;
	logic [vfsr_pkg::SHARD_W-1:0]  shard_q;
	logic                          first_q;
	logic [vfsr_pkg::OFFSET_W-1:0] offset_q;
	logic [WW-1:0]                 data_q;
	logic [vfsr_pkg::COUNT_W-1:0]  count_q;
	logic [AW-1:0]                 addr_q;

	// Frame bookkeeping.
	logic [vfsr_pkg::FRAME_W-1:0]  cur_frame_q;
	logic                          done_q;
	logic [vfsr_pkg::SIZE_W-1:0]   cur_size_q;
	logic [CNW-1:0]                expected_q;
	logic [CNW-1:0]                received_q;
	logic [vfsr_pkg::MARK_W-1:0]   missing_q;
	logic                          taken_q;
	logic [vfsr_pkg::STATUS_W-1:0] hdr_status_q;

	// Output register.
	logic                          out_valid_q;
	logic [vfsr_pkg::STATUS_W-1:0] status_q;
	logic                          rec_q;
	logic [WW-1:0]                 rdata_out_q;
	logic [vfsr_pkg::SIZE_W-1:0]   size_out_q;
	logic [CNW-1:0]                rcv_out_q;

	// Frame buffer.
	logic [WW-1:0] mem [vfsr_pkg::STORE_DEPTH];
	logic [WW-1:0] mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic                          accept;
	logic [ACW-1:0]                addr_calc;
	logic                          is_hdr;
	logic                          same_frame;
	logic                          new_frame;
	logic                          out_free;
	logic                          commit;
	logic                          out_range;
	logic                          dup;
	logic [vfsr_pkg::STATUS_W-1:0] hs_new;
	logic [vfsr_pkg::STATUS_W-1:0] hs_eff;
	logic                          taken_eff;
	logic                          hdr_ok;
	logic                          wr_en;
	logic [WW-1:0]                 base;
	logic [WW-1:0]                 merged;
	logic                          q_fire;
	logic [CNW-1:0]                received_next;
	logic                          sweep_last;
	logic                          clear_end;
	logic                          div_start;
	logic                          div_done;
	logic [vfsr_pkg::SIZE_W-1:0]   div_quo;
	logic [vfsr_pkg::SIZE_W:0]     shard_cnt;
	logic [CNW-1:0]                expected_new;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Word address of the payload word, wrapping over the buffer.
	assign addr_calc = ACW'(shard_index) * ACW'(SHARD_WORDS) + ACW'(word_offset);
	assign mem_re    = accept && (func == vfsr_pkg::FUNC_PACKET || func == vfsr_pkg::FUNC_READ);
	assign mem_raddr = (func == vfsr_pkg::FUNC_READ) ? read_address : addr_calc[AW-1:0];

	// Execute stage decisions.
	assign is_hdr     = (func_q == vfsr_pkg::FUNC_PACKET) && first_q;
	assign same_frame = (cur_frame_q == frame_q);
	assign new_frame  = (state_q == S_EXEC) && is_hdr && !same_frame;
	assign out_free   = !out_valid_q || out_ready;
	assign commit     = (state_q == S_EXEC) && !new_frame && out_free;

	assign out_range = ({1'b0, shard_q} >= expected_q) || (32'(shard_q) >= 32'(MAX_SHARDS));
	assign dup       = !missing_q[shard_q];

	always_comb begin
		if (done_q && same_frame) begin
			hs_new = vfsr_pkg::ST_RECOVERED;
		end else if (out_range) begin
			hs_new = vfsr_pkg::ST_RANGE;
		end else if (dup) begin
			hs_new = vfsr_pkg::ST_DUPLICATE;
		end else begin
			hs_new = vfsr_pkg::ST_ACCEPTED;
		end
	end

	assign hdr_ok    = is_hdr && (hs_new == vfsr_pkg::ST_ACCEPTED);
	assign hs_eff    = is_hdr ? hs_new : hdr_status_q;
	assign taken_eff = is_hdr ? (hs_new == vfsr_pkg::ST_ACCEPTED) : taken_q;
	assign wr_en     = commit && (func_q == vfsr_pkg::FUNC_PACKET) && taken_eff
		&& (32'(offset_q) < 32'(SHARD_WORDS)) && (count_q != '0);

	// Right after a clearing sweep the target word is known to be zero.
	assign base = fresh_q ? '0 : mem_rdata_q;

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			merged[i*8 +: 8] = (count_q > vfsr_pkg::COUNT_W'(i)) ? data_q[i*8 +: 8]
				: base[i*8 +: 8];
		end
	end

	assign q_fire = (func_q == vfsr_pkg::FUNC_QUERY) && !done_q && (received_q >= expected_q);
	assign received_next = (func_q == vfsr_pkg::FUNC_PACKET && hdr_ok) ? received_q + 1'b1
		: received_q;

	// Clearing sweep and shard count.
	assign sweep_last = (sweep_q == '1);
	assign clear_end  = (state_q == S_CLEAR) && sweep_last && div_done;
	assign div_start  = new_frame;

	vfsr_div #(
		.DIVISOR (SHARD_WORDS * 8)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (size_in_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign shard_cnt    = {1'b0, div_quo} + 1'b1;
	assign expected_new = (shard_cnt > (vfsr_pkg::SIZE_W+1)'(vfsr_pkg::SHARD_CNT_MAX))
		? CNW'(vfsr_pkg::SHARD_CNT_MAX) : shard_cnt[CNW-1:0];

	assign mem_we    = (state_q == S_CLEAR) || wr_en;
	assign mem_waddr = (state_q == S_CLEAR) ? sweep_q : addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : merged;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			sweep_q    <= '0;
			ret_exec_q <= 1'b0;
			fresh_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (!(sweep_last && !div_done)) begin
						sweep_q <= sweep_q + 1'b1;
					end
					if (clear_end) begin
						state_q <= ret_exec_q ? S_EXEC : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && func != vfsr_pkg::FUNC_NONE) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (new_frame) begin
						state_q    <= S_CLEAR;
						ret_exec_q <= 1'b1;
						fresh_q    <= 1'b1;
					end else if (out_free) begin
						state_q <= S_IDLE;
						fresh_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			frame_q   <= frame_index;
			size_in_q <= frame_size_bytes;
			shard_q   <= shard_index;
			first_q   <= first_word;
			offset_q  <= word_offset;
			data_q    <= payload_word;
			count_q   <= byte_count;
			addr_q    <= addr_calc[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_frame_q  <= '1;
			done_q       <= 1'b1;
			cur_size_q   <= '0;
			expected_q   <= '0;
			received_q   <= '0;
			missing_q    <= '1;
			taken_q      <= 1'b0;
			hdr_status_q <= vfsr_pkg::ST_RECOVERED;
		end else begin
			// A new frame index resets the frame before any check on the shard.
			if (new_frame) begin
				cur_frame_q <= frame_q;
				done_q      <= 1'b0;
				cur_size_q  <= size_in_q;
				received_q  <= '0;
				missing_q   <= '1;
			end
			if (clear_end && ret_exec_q) begin
				expected_q <= expected_new;
			end
			if (commit && is_hdr) begin
				hdr_status_q <= hs_new;
				taken_q      <= (hs_new == vfsr_pkg::ST_ACCEPTED);
				if (hs_new == vfsr_pkg::ST_ACCEPTED) begin
					missing_q[shard_q] <= 1'b0;
					received_q         <= received_next;
				end
			end
			if (commit && q_fire) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= (func_q == vfsr_pkg::FUNC_PACKET) ? hs_eff : vfsr_pkg::ST_ACCEPTED;
			rec_q       <= q_fire;
			rdata_out_q <= (func_q == vfsr_pkg::FUNC_READ) ? mem_rdata_q : '0;
			size_out_q  <= cur_size_q;
			rcv_out_q   <= received_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign recovered_now   = rec_q;
	assign read_data       = rdata_out_q;
	assign frame_size_out  = size_out_q;
	assign shards_received = rcv_out_q;

endmodule

// ----- rtl/vfsr_checker.sv -----
// Port-level checks for the video frame shard reassembly block, and the bind
// that attaches them to the top level. Depends on vfsr_pkg.
module vfsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [vfsr_pkg::FUNC_W-1:0]   func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [vfsr_pkg::STATUS_W-1:0] status,
	input logic                          recovered_now,
	input logic [vfsr_pkg::WORD_W-1:0]   read_data,
	input logic [vfsr_pkg::SIZE_W-1:0]   frame_size_out,
	input logic [vfsr_pkg::CNT_W-1:0]    shards_received
);

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_data)
			&& $stable(frame_size_out) && $stable(shards_received))
		else $error("result changed while stalled");

	// A real command is executed before the next one is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func != vfsr_pkg::FUNC_NONE |=> !in_ready)
		else $error("input taken while a command was executing");

	// An unused function code produces no result.
	a_none_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == vfsr_pkg::FUNC_NONE |=> !$rose(out_valid))
		else $error("result produced for an unused function code");

	// A recovery answer never comes with a packet status or read data.
	a_rec_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recovered_now |-> status == vfsr_pkg::ST_ACCEPTED && read_data == '0)
		else $error("recovery answer mixed with other result fields");

endmodule

bind video_frame_shard_reassembly vfsr_checker u_vfsr_checker (.*);

// ----- tb/tb_video_frame_shard_reassembly.sv -----
// Self-checking testbench for video_frame_shard_reassembly: directed and random frames of shards.
// A scoreboard class predicts every response from its own copy of the frame state and buffer.
// Depends on vfsr_pkg and the block's RTL only.
module tb_video_frame_shard_reassembly;
	timeunit 1ns;
	timeprecision 1ps;

	import vfsr_pkg::*;

	localparam int SHARD_BYTES  = SHARD_WORDS_DEF * BYTES_PER_WORD;
	localparam int TARGET_ITEMS = 1450;
	localparam int FRAME_CAP    = 70;
	localparam int CYCLE_LIMIT  = 4_000_000;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [FRAME_W-1:0]  frame_index;
		logic [SIZE_W-1:0]   frame_size;
		logic [SHARD_W-1:0]  shard;
		logic                first_word;
		logic [OFFSET_W-1:0] word_offset;
		logic [WORD_W-1:0]   payload;
		logic [COUNT_W-1:0]  byte_count;
		logic [STORE_AW-1:0] read_address;
	} command_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                recovered;
		logic [WORD_W-1:0]   read_data;
		logic [SIZE_W-1:0]   frame_size;
		logic [CNT_W-1:0]    shard_count;
	} response_t;

	class shard_tracker;
		logic [FRAME_W-1:0]  cur_frame;
		bit                  frame_done;
		logic [SIZE_W-1:0]   cur_size;
		int                  expected_count;
		logic [CNT_W-1:0]    received;
		logic [MARK_W-1:0]   missing;
		bit                  packet_taken;
		logic [STATUS_W-1:0] header_status;
		logic [WORD_W-1:0]   store [STORE_DEPTH];
		response_t           pending[$];
		int                  errors;
		int                  frame_starts;

		function new();
			cur_frame = '1;
			frame_done = 1'b1;
			cur_size = '0;
			expected_count = 0;
			received = '0;
			missing = '1;
			packet_taken = 1'b0;
			header_status = ST_RECOVERED;
			errors = 0;
			frame_starts = 0;
			foreach (store[i]) store[i] = '0;
		endfunction

		function int pending_count();
			return pending.size();
		endfunction

		// A header with a new frame index restarts the frame before any range or duplicate check.
		function logic [STATUS_W-1:0] open_header(command_t c);
			if (frame_done && cur_frame == c.frame_index)
				return ST_RECOVERED;
			if (cur_frame != c.frame_index) begin
				cur_frame = c.frame_index;
				frame_done = 1'b0;
				cur_size = c.frame_size;
				expected_count = int'(cur_size) / SHARD_BYTES + 1;
				if (expected_count > SHARD_CNT_MAX)
					expected_count = SHARD_CNT_MAX;
				received = '0;
				missing = '1;
				foreach (store[i]) store[i] = '0;
				frame_starts++;
			end
			if (int'(c.shard) >= expected_count || int'(c.shard) >= MAX_SHARDS_DEF)
				return ST_RANGE;
			if (!missing[c.shard])
				return ST_DUPLICATE;
			missing[c.shard] = 1'b0;
			received = received + 1'b1;
			return ST_ACCEPTED;
		endfunction

		function void merge_word(command_t c);
			logic [WORD_W-1:0] mask;
			int nbytes;
			int addr;
			if (int'(c.word_offset) >= SHARD_WORDS_DEF || c.byte_count == '0)
				return;
			nbytes = int'(c.byte_count);
			if (nbytes > BYTES_PER_WORD)
				nbytes = BYTES_PER_WORD;
			mask = '0;
			for (int b = 0; b < nbytes; b++)
				mask[b*8 +: 8] = 8'hFF;
			addr = (int'(c.shard) * SHARD_WORDS_DEF + int'(c.word_offset)) % STORE_DEPTH;
			store[addr] = (store[addr] & ~mask) | (c.payload & mask);
		endfunction

		function void take_command(command_t c);
			response_t r;
			if (c.func == FUNC_NONE)
				return;
			r = '0;
			case (c.func)
				FUNC_PACKET: begin
					if (c.first_word) begin
						header_status = open_header(c);
						packet_taken = (header_status == ST_ACCEPTED);
					end
					// Later words follow the header decision, even after the frame is recovered.
					if (packet_taken)
						merge_word(c);
					r.status = header_status;
				end
				FUNC_QUERY: begin
					if (!frame_done && int'(received) >= expected_count) begin
						frame_done = 1'b1;
						r.recovered = 1'b1;
					end
				end
				default: begin
					r.read_data = store[c.read_address];
				end
			endcase
			r.frame_size = cur_size;
			r.shard_count = received;
			pending.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task compare_response(response_t got);
			response_t want;
			if (pending.size() == 0) begin
				report("response transfer with nothing outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("status: expected %0d, got %0d", want.status, got.status));
			if (got.recovered !== want.recovered)
				report($sformatf("recovered_now: expected %0d, got %0d",
					want.recovered, got.recovered));
			if (got.read_data !== want.read_data)
				report($sformatf("read_data: expected %h, got %h", want.read_data, got.read_data));
			if (got.frame_size !== want.frame_size)
				report($sformatf("frame_size_out: expected %0d, got %0d",
					want.frame_size, got.frame_size));
			if (got.shard_count !== want.shard_count)
				report($sformatf("shards_received: expected %0d, got %0d",
					want.shard_count, got.shard_count));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [FUNC_W-1:0]   func;
	logic [FRAME_W-1:0]  frame_index;
	logic [SIZE_W-1:0]   frame_size_bytes;
	logic [SHARD_W-1:0]  shard_index;
	logic                first_word;
	logic [OFFSET_W-1:0] word_offset;
	logic [WORD_W-1:0]   payload_word;
	logic [COUNT_W-1:0]  byte_count;
	logic [STORE_AW-1:0] read_address;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                recovered_now;
	logic [WORD_W-1:0]   read_data;
	logic [SIZE_W-1:0]   frame_size_out;
	logic [CNT_W-1:0]    shards_received;

	shard_tracker shards;
	response_t    seen;
	bit           valid_up;
	int           items_counted;
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           cycle_count;

	video_frame_shard_reassembly dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.status = status;
			seen.recovered = recovered_now;
			seen.read_data = read_data;
			seen.frame_size = frame_size_out;
			seen.shard_count = shards_received;
			shards.compare_response(seen);
		end
	end

	function automatic command_t random_cmd();
		command_t c;
		c.func = FUNC_NONE;
		c.frame_index = {$urandom, $urandom};
		c.frame_size = SIZE_W'($urandom_range(0, 65535));
		c.shard = SHARD_W'($urandom_range(0, 63));
		c.first_word = 1'($urandom_range(0, 1));
		c.word_offset = OFFSET_W'($urandom_range(0, 127));
		c.payload = {$urandom, $urandom};
		c.byte_count = COUNT_W'($urandom_range(0, 15));
		c.read_address = STORE_AW'($urandom_range(0, STORE_DEPTH - 1));
		return c;
	endfunction

	task automatic lower_valid();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	task automatic send_cmd(input command_t c);
		if (!valid_up) begin
			in_valid <= 1'b1;
			valid_up = 1'b1;
		end
		func <= c.func;
		frame_index <= c.frame_index;
		frame_size_bytes <= c.frame_size;
		shard_index <= c.shard;
		first_word <= c.first_word;
		word_offset <= c.word_offset;
		payload_word <= c.payload;
		byte_count <= c.byte_count;
		read_address <= c.read_address;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		shards.take_command(c);
		if (c.func != FUNC_NONE)
			items_counted++;
		// Each following cycle the sender stays idle with the chosen probability.
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			lower_valid();
			@(posedge clk);
		end
	endtask

	// The pause lowers valid and waits on the clock before draining, so valid is never dropped and raised in one step.
	task automatic wait_for_drain();
		lower_valid();
		@(posedge clk);
		while (shards.pending_count() != 0)
			@(posedge clk);
	endtask

	task automatic send_word(input logic [FRAME_W-1:0] fidx, input int size, input int shard,
		input bit first, input int offset, input logic [WORD_W-1:0] data, input int count);
		command_t c;
		c = random_cmd();
		c.func = FUNC_PACKET;
		c.frame_index = fidx;
		c.frame_size = SIZE_W'(size);
		c.shard = SHARD_W'(shard);
		c.first_word = first;
		c.word_offset = OFFSET_W'(offset);
		c.payload = data;
		c.byte_count = COUNT_W'(count);
		send_cmd(c);
	endtask

	task automatic send_query();
		command_t c;
		c = random_cmd();
		c.func = FUNC_QUERY;
		send_cmd(c);
	endtask

	task automatic send_read(input int addr);
		command_t c;
		c = random_cmd();
		c.func = FUNC_READ;
		c.read_address = STORE_AW'(addr);
		send_cmd(c);
	endtask

	task automatic run_directed();
		logic [FRAME_W-1:0] f1;
		logic [FRAME_W-1:0] f2;
		command_t c;
		f1 = {$urandom, $urandom};
		f2 = ~f1;
		// Right after reset the all-ones frame counts as already recovered.
		send_word('1, 0, 0, 1'b1, 0, {$urandom, $urandom}, 8);
		send_word('1, 0, 0, 1'b0, 1, {$urandom, $urandom}, 8);
		send_query();
		c = random_cmd();
		send_cmd(c);
		// A rejected header of a new frame still starts that frame.
		send_word(f1, 0, 1, 1'b1, 0, {$urandom, $urandom}, 8);
		send_word(f1, 0, 0, 1'b1, 0, '1, 8);
		send_word(f1, 0, 0, 1'b0, 127, {$urandom, $urandom}, 3);
		send_word(f1, 0, 0, 1'b0, 5, {$urandom, $urandom}, 0);
		send_word(f1, 0, 0, 1'b0, 6, {$urandom, $urandom}, 15);
		send_query();
		send_word(f1, 0, 0, 1'b0, 7, {$urandom, $urandom}, 5);
		send_query();
		send_word(f1, 0, 0, 1'b1, 0, {$urandom, $urandom}, 8);
		send_read(0);
		send_read(127);
		send_read(5);
		send_read(6);
		send_read(7);
		send_word(f2, 65535, 63, 1'b1, 127, '1, 8);
		send_word(f2, 65535, 63, 1'b1, 0, {$urandom, $urandom}, 8);
		send_word(f2, 65535, 63, 1'b0, 1, {$urandom, $urandom}, 8);
		send_word(f2, 65535, 0, 1'b1, 0, {$urandom, $urandom}, 1);
		send_read(STORE_DEPTH - 1);
		send_read(0);
		send_query();
	endtask

	task automatic send_shard_packet(input logic [FRAME_W-1:0] fidx,
		input logic [SIZE_W-1:0] size, input int shard);
		command_t c;
		int words;
		int base;
		words = $urandom_range(1, 6);
		base = $urandom_range(0, SHARD_WORDS_DEF - 1);
		for (int w = 0; w < words; w++) begin
			c = random_cmd();
			c.func = FUNC_PACKET;
			c.first_word = (w == 0);
			c.shard = SHARD_W'(shard);
			if (w == 0) begin
				c.frame_index = fidx;
				c.frame_size = size;
			end
			if ($urandom_range(0, 1) == 1)
				c.word_offset = OFFSET_W'(base + w);
			if ($urandom_range(0, 99) < 70)
				c.byte_count = COUNT_W'(BYTES_PER_WORD);
			send_cmd(c);
		end
	endtask

	task automatic send_noise(input logic [FRAME_W-1:0] fidx, input int nsh);
		command_t c;
		int r;
		c = random_cmd();
		r = $urandom_range(0, 99);
		if (r < 40) begin
			c.func = FUNC_READ;
			c.read_address = STORE_AW'($urandom_range(0, nsh - 1) * SHARD_WORDS_DEF
				+ $urandom_range(0, SHARD_WORDS_DEF - 1));
		end else if (r < 55) begin
			c.func = FUNC_READ;
		end else if (r < 70) begin
			c.func = FUNC_QUERY;
		end else if (r < 80) begin
			c.func = FUNC_NONE;
		end else if (r < 90) begin
			c.func = FUNC_PACKET;
			c.first_word = 1'b0;
		end else if (r < 97) begin
			c.func = FUNC_PACKET;
			c.first_word = 1'b1;
			c.frame_index = fidx;
		end else begin
			// A stray header for another frame abandons the one in progress, until the frame cap is reached.
			c.func = FUNC_PACKET;
			c.first_word = 1'b1;
			if (shards.frame_starts >= FRAME_CAP)
				c.frame_index = fidx;
		end
		send_cmd(c);
	endtask

	task automatic run_frame();
		int order [MAX_SHARDS_DEF];
		int nsh;
		int nsend;
		int r;
		int j;
		int t;
		logic [FRAME_W-1:0] fidx;
		logic [SIZE_W-1:0] size;
		r = $urandom_range(0, 99);
		if (r < 30)
			nsh = 1;
		else if (r < 96)
			nsh = $urandom_range(2, 8);
		else
			nsh = MAX_SHARDS_DEF;
		size = SIZE_W'((nsh - 1) * SHARD_BYTES + $urandom_range(0, SHARD_BYTES - 1));
		fidx = (shards.frame_starts < FRAME_CAP) ? {$urandom, $urandom} : shards.cur_frame;
		for (int i = 0; i < nsh; i++)
			order[i] = i;
		for (int i = nsh - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		// Most frames arrive whole; the rest stop short.
		nsend = ($urandom_range(0, 99) < 80) ? nsh : $urandom_range(0, nsh - 1);
		for (int k = 0; k < nsend; k++) begin
			if ($urandom_range(0, 99) < 15)
				send_noise(fidx, nsh);
			if (nsh < MAX_SHARDS_DEF && $urandom_range(0, 99) < 8)
				send_shard_packet(fidx, size, $urandom_range(nsh, MAX_SHARDS_DEF - 1));
			send_shard_packet(fidx, size, order[k]);
			if ($urandom_range(0, 99) < 8)
				send_shard_packet(fidx, size, order[$urandom_range(0, k)]);
		end
		send_query();
		repeat ($urandom_range(3, 12)) send_noise(fidx, nsh);
	endtask

	initial begin
		shards = new();
		valid_up = 1'b0;
		items_counted = 0;
		tx_idle_pct = 38;
		rx_idle_pct = 82;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_NONE;
		frame_index <= '0;
		frame_size_bytes <= '0;
		shard_index <= '0;
		first_word <= 1'b0;
		word_offset <= '0;
		payload_word <= '0;
		byte_count <= '0;
		read_address <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				tx_idle_pct = 82;
				rx_idle_pct = 38;
			end else if (phase == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			while (items_counted < TARGET_ITEMS * (phase + 1) / 3)
				run_frame();
			wait_for_drain();
		end
		repeat (40) @(posedge clk);
		if (shards.errors == 0 && shards.pending_count() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/vfsr_pkg.sv
rtl/vfsr_div.sv
rtl/video_frame_shard_reassembly.sv
rtl/vfsr_checker.sv
tb/tb_video_frame_shard_reassembly.sv
